// ===== hdl/cac_pkg.sv =====
// Shared types and widths for the cubic axis response curve.
package cac_pkg;

  localparam int FACTOR_FRAC_BITS = 8;
  localparam int ONE = 1 << FACTOR_FRAC_BITS;

  localparam int AX_W   = 8;
  localparam int FAC_W  = 16;
  localparam int M_W    = AX_W - 1;
  localparam int D_W    = AX_W;
  localparam int M2_W   = 2 * M_W;
  localparam int D2_W   = 2 * D_W;
  localparam int XF_W   = AX_W + FAC_W;
  localparam int M3_W   = 3 * M_W;
  localparam int D3_W   = 3 * D_W;
  localparam int XFM2_W = XF_W + M2_W;
  localparam int SUM_W  = FAC_W + 1;
  localparam int DEN_W  = M2_W + SUM_W;
  localparam int CUB_W  = D3_W;
  localparam int NUM_W  = XFM2_W + 2;
  localparam int N_W    = NUM_W + 2;
  localparam int QUO_W  = 10;

  localparam logic [AX_W-1:0]  RANGE_RST  = AX_W'(255);
  localparam logic [FAC_W-1:0] FACTOR_RST = FAC_W'(256);

  typedef enum logic {
    REG_AXIS_RANGE   = 1'b0,
    REG_CURVE_FACTOR = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic             valid;
    logic [N_W-1:0]   rem;
    logic [N_W-1:0]   dsh;
    logic [QUO_W-1:0] quo;
    logic [AX_W-1:0]  x;
    logic             bypass;
  } div_t;

endpackage

// ===== hdl/cubic_axis_response_curve.sv =====
// Top level of the cubic axis response curve.
//
// Usage:
//   Input channel (in_valid / in_stall / axis_position) takes one raw axis
//   reading per transaction; output channel (out_valid / out_stall /
//   shaped_position) returns one reshaped reading per transaction, in order.
//   Configuration: pulse cfg_we with cfg_index (axis_range or curve_factor)
//   and cfg_data; write only while no transaction is in flight.
// Pipeline: the accepting edge loads the first of 15 registers: four front
//   stages (clamp, squares and x*f, cubes and products, dividend setup), ten
//   division cells (one quotient bit each), one output register.
// Throughput: one transaction per cycle unless stalled; every stage is
//   registered, the division spread over the cell chain, one bit per cell.
// Reset: rst (synchronous) empties every stage, drops out_valid and loads
//   axis_range = 255, curve_factor = 256 (1.0).
// Stall: while out_stall holds a result, the output register keeps it and
//   upstream stages keep filling bubbles; in_stall rises only once every
//   stage holds a transaction.
module cubic_axis_response_curve (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [cac_pkg::AX_W-1:0]  axis_position,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [cac_pkg::AX_W-1:0]  shaped_position,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [cac_pkg::FAC_W-1:0] cfg_data
);
  import cac_pkg::*;

  logic [AX_W-1:0]  axis_range;
  logic [FAC_W-1:0] curve_factor;

  div_t bus [QUO_W+1];
  logic bus_ready [QUO_W+1];
  logic in_ready;

  logic             out_ready;
  logic [AX_W-1:0]  shaped_next;
  logic [QUO_W-1:0] quo;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      axis_range   <= RANGE_RST;
      curve_factor <= FACTOR_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_AXIS_RANGE:   axis_range   <= cfg_data[AX_W-1:0];
        REG_CURVE_FACTOR: curve_factor <= cfg_data;
        default:          ;
      endcase
    end
  end

  assign in_stall = !in_ready;

  cac_prep u_prep (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .axis_position (axis_position),
    .axis_range    (axis_range),
    .curve_factor  (curve_factor),
    .dn            (bus[0]),
    .dn_ready      (bus_ready[0])
  );

  // Division chain: cell k resolves quotient bit QUO_W-1-k.
  for (genvar k = 0; k < QUO_W; k++) begin : g_cell
    cac_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up       (bus[k]),
      .up_ready (bus_ready[k]),
      .dn       (bus[k+1]),
      .dn_ready (bus_ready[k+1])
    );
  end

  // Output register: clamp to the range, or pass the reading through when
  // the half range is zero and the curve is undefined.
  assign out_ready          = !out_valid || !out_stall;
  assign bus_ready[QUO_W]   = out_ready;
  assign quo                = bus[QUO_W].quo;

  always_comb begin
    if (bus[QUO_W].bypass) begin
      shaped_next = bus[QUO_W].x;
    end else if (quo > QUO_W'(axis_range)) begin
      shaped_next = axis_range;
    end else begin
      shaped_next = quo[AX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= bus[QUO_W].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) shaped_position <= shaped_next;
  end

endmodule

// ===== hdl/cac_prep.sv =====
// Front pipeline: clamp, powers and products, dividend and divisor setup.
module cac_prep (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [cac_pkg::AX_W-1:0]  axis_position,
  input  logic [cac_pkg::AX_W-1:0]  axis_range,
  input  logic [cac_pkg::FAC_W-1:0] curve_factor,
  output cac_pkg::div_t             dn,
  input  logic                      dn_ready
);
  import cac_pkg::*;

  typedef struct packed {
    logic            valid;
    logic [AX_W-1:0] x;
    logic [M_W-1:0]  m;
    logic [D_W-1:0]  d;
    logic            below;
    logic            bypass;
  } s0_t;

  typedef struct packed {
    logic              valid;
    logic [AX_W-1:0]   x;
    logic [M_W-1:0]    m;
    logic [D_W-1:0]    d;
    logic [M2_W-1:0]   m2;
    logic [D2_W-1:0]   d2;
    logic [XF_W-1:0]   xf;
    logic              below;
    logic              bypass;
  } s1_t;

  typedef struct packed {
    logic              valid;
    logic [AX_W-1:0]   x;
    logic [M3_W-1:0]   m3;
    logic [D3_W-1:0]   d3;
    logic [XFM2_W-1:0] xfm2;
    logic [DEN_W-1:0]  den;
    logic              below;
    logic              bypass;
  } s2_t;

  s0_t s0, s0_next;
  s1_t s1, s1_next;
  s2_t s2, s2_next;
  div_t dn_next;
  logic rdy0, rdy1, rdy2, rdy3;

  logic [AX_W-1:0]  x_c;
  logic [SUM_W-1:0] one_plus_f;
  logic [CUB_W-1:0] cub;
  logic [NUM_W-1:0] num;
  logic [N_W-1:0]   dvs;

  // A stage takes new data when it is empty or its successor moves.
  assign rdy3     = !dn.valid || dn_ready;
  assign rdy2     = !s2.valid || rdy3;
  assign rdy1     = !s1.valid || rdy2;
  assign rdy0     = !s0.valid || rdy1;
  assign in_ready = rdy0;

  always_comb begin
    x_c = (axis_position > axis_range) ? axis_range : axis_position;
    s0_next.valid  = in_valid;
    s0_next.x      = x_c;
    s0_next.m      = axis_range[AX_W-1:1];
    s0_next.below  = x_c < {1'b0, axis_range[AX_W-1:1]};
    s0_next.d      = s0_next.below ? ({1'b0, s0_next.m} - x_c) : (x_c - {1'b0, s0_next.m});
    s0_next.bypass = (s0_next.m == '0);
  end

  always_comb begin
    s1_next.valid  = s0.valid;
    s1_next.x      = s0.x;
    s1_next.m      = s0.m;
    s1_next.d      = s0.d;
    s1_next.m2     = M2_W'(s0.m) * M2_W'(s0.m);
    s1_next.d2     = D2_W'(s0.d) * D2_W'(s0.d);
    s1_next.xf     = XF_W'(s0.x) * XF_W'(curve_factor);
    s1_next.below  = s0.below;
    s1_next.bypass = s0.bypass;
  end

  always_comb begin
    one_plus_f     = SUM_W'(ONE) + SUM_W'(curve_factor);
    s2_next.valid  = s1.valid;
    s2_next.x      = s1.x;
    s2_next.m3     = M3_W'(s1.m2) * M3_W'(s1.m);
    s2_next.d3     = D3_W'(s1.d2) * D3_W'(s1.d);
    s2_next.xfm2   = XFM2_W'(s1.xf) * XFM2_W'(s1.m2);
    s2_next.den    = DEN_W'(s1.m2) * DEN_W'(one_plus_f);
    s2_next.below  = s1.below;
    s2_next.bypass = s1.bypass;
  end

  // Dividend is 2*num + den and divisor 2*den, so the quotient rounds half up.
  always_comb begin
    cub = s2.below ? (CUB_W'(s2.m3) - s2.d3) : (CUB_W'(s2.m3) + s2.d3);
    num = (NUM_W'(cub) << FACTOR_FRAC_BITS) + NUM_W'(s2.xfm2);
    dvs = N_W'(s2.den) << 1;
    dn_next.valid  = s2.valid;
    dn_next.rem    = (N_W'(num) << 1) + N_W'(s2.den);
    dn_next.dsh    = dvs << (QUO_W - 1);
    dn_next.quo    = '0;
    dn_next.x      = s2.x;
    dn_next.bypass = s2.bypass;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0.valid <= 1'b0;
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
      dn.valid <= 1'b0;
    end else begin
      if (rdy0) s0 <= s0_next;
      if (rdy1) s1 <= s1_next;
      if (rdy2) s2 <= s2_next;
      if (rdy3) dn <= dn_next;
    end
  end

endmodule

// ===== hdl/cac_div_cell.sv =====
// One restoring-division cell: resolves one quotient bit and passes on.
module cac_div_cell (
  input  logic          clk,
  input  logic          rst,
  input  cac_pkg::div_t up,
  output logic          up_ready,
  output cac_pkg::div_t dn,
  input  logic          dn_ready
);
  import cac_pkg::*;

  div_t dn_next;
  logic ge;

  assign up_ready = !dn.valid || dn_ready;

  always_comb begin
    ge = (up.rem >= up.dsh);
    dn_next        = up;
    dn_next.rem    = ge ? (up.rem - up.dsh) : up.rem;
    dn_next.dsh    = up.dsh >> 1;
    dn_next.quo    = {up.quo[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) dn.valid <= 1'b0;
    else if (up_ready) dn <= dn_next;
  end

endmodule

// ===== hdl/cac_checker.sv =====
// Port-level checks for the cubic axis response curve, bound to the top level.
module cac_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [cac_pkg::AX_W-1:0]  shaped_position,
  input logic                      cfg_we,
  input logic                      cfg_index,
  input logic [cac_pkg::FAC_W-1:0] cfg_data
);
  import cac_pkg::*;

  logic [AX_W-1:0] range_shadow;

  // Track the range register from the configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      range_shadow <= RANGE_RST;
    end else if (cfg_we && cfg_reg_t'(cfg_index) == REG_AXIS_RANGE) begin
      range_shadow <= cfg_data[AX_W-1:0];
    end
  end

  a_reset_empties: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set right after reset");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(shaped_position))
    else $error("stalled result changed or dropped");

  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && out_stall) |-> !in_stall)
    else $error("input stalled while output side can move");

  a_within_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> shaped_position <= range_shadow)
    else $error("result above axis range");

endmodule

bind cubic_axis_response_curve cac_checker u_cac_checker (.*);
